// ===== rtl/tta_pkg.sv =====
package tta_pkg;

    localparam int TS_W             = 32;
    localparam int CFG_W            = 16;
    localparam int TEMPO_W          = 20;
    localparam int HELD_W           = 3;
    localparam int FRAC_W           = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int OUT_DATA_W       = 24;
    localparam int WINDOW_SLOTS_DEF = 4;

    localparam logic [CFG_W-1:0]   TIMEOUT_RST   = 16'd2000;
    localparam logic [CFG_W-1:0]   MIN_GAP_RST   = 16'd20;
    localparam logic [CFG_W-1:0]   TEMPO_MIN_RST = 16'd20;
    localparam logic [CFG_W-1:0]   TEMPO_MAX_RST = 16'd1000;
    localparam logic [TEMPO_W-1:0] TEMPO_RST     = 20'd4800;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OC_FIRST  = 2'd0,
        OC_STALE  = 2'd1,
        OC_BOUNCE = 2'd2,
        OC_ACCEPT = 2'd3
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 2'd0,
        CFG_MIN_GAP   = 2'd1,
        CFG_TEMPO_MIN = 2'd2,
        CFG_TEMPO_MAX = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic done;
        logic gt_timeout;
        logic lt_min;
    } gap_stat_t;

endpackage

// ===== rtl/tta_gap_serial.sv =====
module tta_gap_serial
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tta_pkg::TS_W-1:0]   now_ms,
    input  logic [tta_pkg::TS_W-1:0]   last_ms,
    input  logic [tta_pkg::CFG_W-1:0]  timeout_ms,
    input  logic [tta_pkg::CFG_W-1:0]  min_gap_ms,
    output logic [tta_pkg::CFG_W-1:0]  gap,
    output tta_pkg::gap_stat_t         stat
);
    import tta_pkg::*;

    localparam int BC_W = $clog2(TS_W);

    logic [TS_W-1:0] a_reg, a_next;
    logic [TS_W-1:0] b_reg, b_next;
    logic [TS_W-1:0] t_reg, t_next;
    logic [TS_W-1:0] m_reg, m_next;
    logic [TS_W-1:0] gap_reg, gap_next;
    logic            carry_reg, carry_next;
    logic            gt_reg, gt_next;
    logic            lt_reg, lt_next;
    logic [BC_W-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            nb;
    logic            d;

    // one difference bit per cycle, lsb first: a + ~b + 1
    assign nb = ~b_reg[0];
    assign d  = a_reg[0] ^ nb ^ carry_reg;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        t_next     = t_reg;
        m_next     = m_reg;
        gap_next   = gap_reg;
        carry_next = carry_reg;
        gt_next    = gt_reg;
        lt_next    = lt_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            a_next     = now_ms;
            b_next     = last_ms;
            t_next     = TS_W'(timeout_ms);
            m_next     = TS_W'(min_gap_ms);
            carry_next = 1'b1;
            gt_next    = 1'b0;
            lt_next    = 1'b0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next     = {1'b0, a_reg[TS_W-1:1]};
            b_next     = {1'b0, b_reg[TS_W-1:1]};
            t_next     = {1'b0, t_reg[TS_W-1:1]};
            m_next     = {1'b0, m_reg[TS_W-1:1]};
            gap_next   = {d, gap_reg[TS_W-1:1]};
            carry_next = (a_reg[0] & nb) | (a_reg[0] & carry_reg) | (nb & carry_reg);
            // the highest differing bit decides each compare
            if (d != t_reg[0])
            begin
                gt_next = d;
            end
            if (d != m_reg[0])
            begin
                lt_next = ~d;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BC_W'(TS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        t_reg     <= t_next;
        m_reg     <= m_next;
        gap_reg   <= gap_next;
        carry_reg <= carry_next;
        gt_reg    <= gt_next;
        lt_reg    <= lt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign gap             = gap_reg[CFG_W-1:0];
    assign stat.done       = done_reg;
    assign stat.gt_timeout = gt_reg;
    assign stat.lt_min     = lt_reg;

endmodule

// ===== rtl/tta_window.sv =====
module tta_window
#(
    parameter int SLOTS = tta_pkg::WINDOW_SLOTS_DEF,
    parameter int CNT_W = $clog2(SLOTS + 1),
    parameter int SUM_W = tta_pkg::CFG_W + CNT_W
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clr,
    input  logic                      push,
    input  logic [tta_pkg::CFG_W-1:0] gap,
    output logic [CNT_W-1:0]          count,
    output logic [SUM_W-1:0]          sum
);
    import tta_pkg::*;

    logic [CFG_W-1:0] win_reg [SLOTS];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             full;
    logic [SUM_W-1:0] drop;

    assign full = (count_reg == CNT_W'(SLOTS));
    assign drop = full ? SUM_W'(win_reg[0]) : '0;

    // running sum of the held intervals
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (clr)
        begin
            count_next = '0;
            sum_next   = '0;
        end
        else if (push)
        begin
            sum_next = sum_reg + SUM_W'(gap) - drop;
            if (!full)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !clr)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (full)
                begin
                    if (i == SLOTS - 1)
                    begin
                        win_reg[i] <= gap;
                    end
                    else
                    begin
                        win_reg[i] <= win_reg[(i + 1) % SLOTS];
                    end
                end
                else if (count_reg == CNT_W'(i))
                begin
                    win_reg[i] <= gap;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign count = count_reg;
    assign sum   = sum_reg;

endmodule

// ===== rtl/tta_divider.sv =====
module tta_divider
#(
    parameter int DVD_W = 23,
    parameter int DVS_W = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int DC_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DC_W-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] trial;
    logic             borrow;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - (DVS_W + 2)'(dvs_reg);
    assign borrow  = trial[DVS_W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = borrow ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ~borrow};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DC_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/tap_tempo_averager_unit.sv =====
// Tap tempo averager: one request on s_tdata is one tap time in ms; each tap gives one
// result with the averaged tempo (Q16.4 ms), the tempo-set flag, the window fill and the
// outcome in m_tuser. A first tap goes straight to the done state. Every later tap goes
// through a bit-serial subtract and compare of the 32-bit timestamps in the gap state,
// which decides; a stale restart or bounce goes on to the done state. An accepted
// interval updates the window and passes the load state, which starts a restoring divider
// that yields one quotient bit per cycle for a 16 + 4 + clog2(WINDOW_SLOTS+1)-bit quotient
// (23 bits with four slots); the tempo is latched when the divider is done. In the done state
// the result goes to the output register once it is free; only then is the next tap taken.
module tap_tempo_averager_unit
#(
    parameter int WINDOW_SLOTS = tta_pkg::WINDOW_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tta_pkg::TS_W-1:0]      s_tdata,    // now_ms[31:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tempo_q4[19:0], tempo_set[20], intervals_held[23:21]
    output logic [tta_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser,    // outcome[1:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tta_pkg::CFG_W-1:0]     cfg_data
);
    import tta_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
    localparam int SUM_W = CFG_W + CNT_W;
    localparam int QW    = SUM_W + FRAC_W;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  timeout_reg, min_gap_reg, tempo_min_reg, tempo_max_reg;
    logic [TS_W-1:0]   last_reg;
    logic              have_prev_reg;
    logic [TEMPO_W-1:0] tempo_reg, tempo_next;
    logic              tempo_valid_reg;
    outcome_t          outcome_reg, outcome_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    logic              in_take;
    logic              gap_start;
    logic              win_push;
    logic              win_clr;
    logic              div_start;
    logic              out_load;
    logic              out_free;

    logic [CFG_W-1:0]  gap;
    gap_stat_t         gstat;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic              div_done;
    logic [QW-1:0]     quot;
    logic [QW-1:0]     lo_q, hi_q, q_lo;
    logic [CNT_W+2:0]  count_ext;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_take   = s_tvalid && s_tready;
    assign gap_start = in_take && have_prev_reg;

    tta_gap_serial u_gap
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (gap_start),
        .now_ms     (s_tdata),
        .last_ms    (last_reg),
        .timeout_ms (timeout_reg),
        .min_gap_ms (min_gap_reg),
        .gap        (gap),
        .stat       (gstat)
    );

    tta_window #(
        .SLOTS (WINDOW_SLOTS),
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_win
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (win_clr),
        .push  (win_push),
        .gap   (gap),
        .count (count),
        .sum   (sum)
    );

    tta_divider #(
        .DVD_W (QW),
        .DVS_W (CNT_W)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum, FRAC_W'(0)}),
        .divisor  (count),
        .done     (div_done),
        .quotient (quot)
    );

    // clamp: lower limit first, upper limit wins
    assign lo_q = QW'({tempo_min_reg, FRAC_W'(0)});
    assign hi_q = QW'({tempo_max_reg, FRAC_W'(0)});
    assign q_lo = (quot < lo_q) ? lo_q : quot;

    always_comb
    begin
        tempo_next = tempo_reg;
        if (div_done)
        begin
            tempo_next = (q_lo > hi_q) ? hi_q[TEMPO_W-1:0] : q_lo[TEMPO_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        outcome_next = outcome_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (have_prev_reg)
                    begin
                        state_next = ST_GAP;
                    end
                    else
                    begin
                        state_next   = ST_DONE;
                        outcome_next = OC_FIRST;
                    end
                end
            end
            ST_GAP:
            begin
                if (gstat.done)
                begin
                    if (gstat.gt_timeout)
                    begin
                        state_next   = ST_DONE;
                        outcome_next = OC_STALE;
                    end
                    else if (gstat.lt_min)
                    begin
                        state_next   = ST_DONE;
                        outcome_next = OC_BOUNCE;
                    end
                    else
                    begin
                        state_next   = ST_LOAD;
                        outcome_next = OC_ACCEPT;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = 1'b0;
        win_clr   = 1'b0;
        win_push  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_GAP:
            begin
                if (gstat.done)
                begin
                    win_clr  = gstat.gt_timeout;
                    win_push = !gstat.gt_timeout && !gstat.lt_min;
                end
            end
            ST_LOAD:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
            begin
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign count_ext = (CNT_W + 3)'(count);

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            last_reg <= s_tdata;
        end
        if (out_load)
        begin
            m_tdata_reg <= {count_ext[HELD_W-1:0], tempo_valid_reg, tempo_reg};
            m_tuser_reg <= outcome_reg;
        end
        outcome_reg <= outcome_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            have_prev_reg   <= 1'b0;
            tempo_reg       <= TEMPO_RST;
            tempo_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            timeout_reg     <= TIMEOUT_RST;
            min_gap_reg     <= MIN_GAP_RST;
            tempo_min_reg   <= TEMPO_MIN_RST;
            tempo_max_reg   <= TEMPO_MAX_RST;
        end
        else
        begin
            state_reg    <= state_next;
            tempo_reg    <= tempo_next;
            m_tvalid_reg <= m_tvalid_next;
            if (in_take)
            begin
                have_prev_reg <= 1'b1;
            end
            if (div_done)
            begin
                tempo_valid_reg <= 1'b1;
            end
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                    CFG_MIN_GAP:   min_gap_reg   <= cfg_data;
                    CFG_TEMPO_MIN: tempo_min_reg <= cfg_data;
                    CFG_TEMPO_MAX: tempo_max_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== test/tb_tap_tempo_averager_unit.sv =====
module tb_tap_tempo_averager_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tta_pkg::*;

    localparam int SLOTS      = WINDOW_SLOTS_DEF;
    localparam int PHASES     = 8;
    localparam int TAPS_PHASE = 150;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo;
        logic               set;
        outcome_t           outcome;
        logic [HELD_W-1:0]  held;
    } tap_result_t;

    typedef struct {
        logic [TS_W-1:0] now;
        bit              typed;
        tap_result_t     res;
    } tap_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TS_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // predictor state
    logic [CFG_W-1:0]   timeout_cfg = TIMEOUT_RST;
    logic [CFG_W-1:0]   min_gap_cfg = MIN_GAP_RST;
    logic [CFG_W-1:0]   tempo_lo_cfg = TEMPO_MIN_RST;
    logic [CFG_W-1:0]   tempo_hi_cfg = TEMPO_MAX_RST;
    logic [TS_W-1:0]    last_tap = '0;
    bit                 have_prev = 1'b0;
    logic [CFG_W-1:0]   gap_win [SLOTS];
    int unsigned        win_fill = 0;
    logic [TEMPO_W-1:0] tempo_now = TEMPO_RST;
    bit                 tempo_ok = 1'b0;

    tap_result_t tempo_due_q [$];
    tap_row_t    tap_script [$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    bit          squeeze_done = 1'b0;
    int          taps_sent = 0;
    int          hold_left = 0;

    tap_tempo_averager_unit #(
        .WINDOW_SLOTS (SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic tap_result_t tap_to_tempo(input logic [TS_W-1:0] now);
        tap_result_t r;
        logic [31:0] gap;
        logic [31:0] sum;
        logic [31:0] q;
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned i;
        r.outcome = OC_FIRST;
        if (have_prev)
        begin
            gap = now - last_tap;
            if (gap > {16'd0, timeout_cfg})
            begin
                win_fill = 0;
                r.outcome = OC_STALE;
            end
            else if (gap < {16'd0, min_gap_cfg})
            begin
                r.outcome = OC_BOUNCE;
            end
            else
            begin
                if (win_fill < SLOTS)
                begin
                    gap_win[win_fill] = gap[CFG_W-1:0];
                    win_fill++;
                end
                else
                begin
                    for (i = 1; i < SLOTS; i++)
                        gap_win[i-1] = gap_win[i];
                    gap_win[SLOTS-1] = gap[CFG_W-1:0];
                end
                sum = 0;
                for (i = 0; i < win_fill; i++)
                    sum += {16'd0, gap_win[i]};
                q = (sum * 32'd16) / win_fill;
                lo = {16'd0, tempo_lo_cfg} * 32'd16;
                hi = {16'd0, tempo_hi_cfg} * 32'd16;
                // upper clamp applied last so it wins when the limits cross
                if (q < lo)
                    q = lo;
                if (q > hi)
                    q = hi;
                tempo_now = q[TEMPO_W-1:0];
                tempo_ok = 1'b1;
                r.outcome = OC_ACCEPT;
            end
        end
        last_tap = now;
        have_prev = 1'b1;
        r.tempo = tempo_now;
        r.set = tempo_ok;
        r.held = win_fill[HELD_W-1:0];
        return r;
    endfunction

    // mostly well-formed gaps for the current limits, the rest stale, bounce or random times
    function automatic logic [TS_W-1:0] pick_tap_time();
        int unsigned pick;
        logic [31:0] gap;
        logic [31:0] tmo;
        logic [31:0] mg;
        tmo = {16'd0, timeout_cfg};
        mg = {16'd0, min_gap_cfg};
        pick = $urandom_range(0, 99);
        if (pick >= 90)
            return $urandom;
        if (pick < 70 && mg <= tmo)
        begin
            if (pick < 8)
                gap = mg;
            else if (pick < 16)
                gap = tmo;
            else
                gap = $urandom_range(tmo, mg);
        end
        else if (pick >= 70 && pick < 80 && mg > 0)
        begin
            gap = $urandom_range(mg - 1, 0);
        end
        else if (pick < 85)
        begin
            gap = tmo + 1;
        end
        else
        begin
            gap = $urandom;
            if (gap <= tmo)
                gap = tmo + 1;
        end
        return last_tap + gap;
    endfunction

    function automatic void add_row(input logic [TS_W-1:0] now, input bit typed,
                                    input logic [TEMPO_W-1:0] tempo, input logic set,
                                    input outcome_t oc, input logic [HELD_W-1:0] held);
        tap_row_t row;
        row.now = now;
        row.typed = typed;
        row.res.tempo = tempo;
        row.res.set = set;
        row.res.outcome = oc;
        row.res.held = held;
        tap_script.push_back(row);
    endfunction

    task automatic offer_tap(input logic [TS_W-1:0] now, input bit typed,
                             input tap_result_t typed_res);
        tap_result_t pred;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= now;
        do
            @(posedge clk);
        while (!s_tready);
        pred = tap_to_tempo(now);
        tempo_due_q.push_back(typed ? typed_res : pred);
        taps_sent++;
    endtask

    task automatic program_limits(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] mg,
                                  input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        cfg_idx_t         idx [4];
        logic [CFG_W-1:0] val [4];
        int               i;
        idx[0] = CFG_TIMEOUT;
        idx[1] = CFG_MIN_GAP;
        idx[2] = CFG_TEMPO_MIN;
        idx[3] = CFG_TEMPO_MAX;
        val[0] = tmo;
        val[1] = mg;
        val[2] = lo;
        val[3] = hi;
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        timeout_cfg = tmo;
        min_gap_cfg = mg;
        tempo_lo_cfg = lo;
        tempo_hi_cfg = hi;
    endtask

    // output side: checks every result and stalls in short bursts, once for a long stretch
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tempo_due_q.size() == 0)
            begin
                $error("result with no tap request pending");
                failed = 1'b1;
            end
            else
            begin
                tap_result_t e;
                e = tempo_due_q.pop_front();
                if (m_tdata[19:0] !== e.tempo)
                begin
                    $error("tempo_q4: expected %0d, got %0d", e.tempo, m_tdata[19:0]);
                    failed = 1'b1;
                end
                if (m_tdata[20] !== e.set)
                begin
                    $error("tempo_set: expected %0d, got %0d", e.set, m_tdata[20]);
                    failed = 1'b1;
                end
                if (m_tdata[23:21] !== e.held)
                begin
                    $error("intervals_held: expected %0d, got %0d", e.held, m_tdata[23:21]);
                    failed = 1'b1;
                end
                if (m_tuser !== e.outcome)
                begin
                    $error("outcome: expected %0d, got %0d", e.outcome, m_tuser);
                    failed = 1'b1;
                end
            end
        end
        if (!squeeze_done && taps_sent >= 400)
        begin
            squeeze_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            hold_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        tap_result_t no_res;
        int          p;
        int          n;
        logic [CFG_W-1:0] tmo;

        no_res = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: timeout 2000, min gap 20, clamp 20..1000 ms
        add_row(32'd0, 1'b1, 20'd4800, 1'b0, OC_FIRST, 3'd0);      // zero time is a real tap
        add_row(32'd10, 1'b1, 20'd4800, 1'b0, OC_BOUNCE, 3'd0);
        add_row(32'd5010, 1'b1, 20'd4800, 1'b0, OC_STALE, 3'd0);
        add_row(32'd5510, 1'b1, 20'd8000, 1'b1, OC_ACCEPT, 3'd1);
        add_row(32'd6010, 1'b0, '0, 1'b0, OC_FIRST, '0);
        add_row(32'd6030, 1'b0, '0, 1'b0, OC_FIRST, '0);             // gap equal to min gap
        add_row(32'd8030, 1'b0, '0, 1'b0, OC_FIRST, '0);             // gap equal to timeout
        add_row(32'd8530, 1'b0, '0, 1'b0, OC_FIRST, '0);             // window slides
        add_row(32'd8531, 1'b0, '0, 1'b0, OC_FIRST, '0);
        add_row(32'd10532, 1'b0, '0, 1'b0, OC_FIRST, '0);            // one past timeout
        add_row(32'd12032, 1'b1, 20'd16000, 1'b1, OC_ACCEPT, 3'd1);  // upper clamp
        add_row(32'hFFFF_FFF0, 1'b0, '0, 1'b0, OC_FIRST, '0);
        add_row(32'h0000_01E0, 1'b0, '0, 1'b0, OC_FIRST, '0);        // gap across clock wrap
        add_row(32'hFFFF_FFFF, 1'b0, '0, 1'b0, OC_FIRST, '0);
        add_row(32'h0000_0000, 1'b0, '0, 1'b0, OC_FIRST, '0);
        add_row(32'h0000_0000, 1'b0, '0, 1'b0, OC_FIRST, '0);        // zero gap
        add_row(32'h0000_03E8, 1'b0, '0, 1'b0, OC_FIRST, '0);
        foreach (tap_script[i])
            offer_tap(tap_script[i].now, tap_script[i].typed, tap_script[i].res);

        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                s_tvalid <= 1'b0;
                while (tempo_due_q.size() != 0)
                    @(posedge clk);
                repeat (2) @(posedge clk);
                case (p)
                    1: program_limits(16'd1000, 16'd50, 16'd100, 16'd600);
                    2: program_limits(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
                    3: program_limits(16'd0, 16'd0, 16'hFFFF, 16'd0);
                    4: program_limits(16'hFFFF, 16'hFFFF, 16'd30, 16'd40);
                    7: program_limits(16'd500, 16'd10, 16'd0, 16'd200);
                    default:
                    begin
                        tmo = CFG_W'($urandom_range(200, 65535));
                        program_limits(tmo, CFG_W'($urandom_range(0, tmo / 4)),
                                       CFG_W'($urandom_range(0, 2000)),
                                       CFG_W'($urandom_range(0, 65535)));
                    end
                endcase
            end
            if (p == PHASES - 1)
                quiet = 1'b1;
            for (n = 0; n < TAPS_PHASE; n++)
                offer_tap(pick_tap_time(), 1'b0, no_res);
        end
        s_tvalid <= 1'b0;

        while (tempo_due_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (!failed && tempo_due_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
